// ----- sv/rrc_pkg.sv -----
// Shared types and codes for the rectangle raster canvas.
// Holds the beat structs, command, status and register codes.
// No dependencies.
package rrc_pkg;

	localparam int COORD_W = 24;
	localparam int SUM_W   = COORD_W + 1;
	localparam int CFG_W   = 9;
	localparam int IDX_W   = 2;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_DRAW  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_SIZE = 2'd1,
		STATUS_OUTSIDE  = 2'd2,
		STATUS_SPARE    = 2'd3
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_CANVAS_WIDTH  = 2'd0,
		REG_CANVAS_HEIGHT = 2'd1,
		REG_BACKGROUND    = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                command;
		logic                      fill_mode;
		logic signed [COORD_W-1:0] rect_x;
		logic signed [COORD_W-1:0] rect_y;
		logic signed [COORD_W-1:0] rect_width;
		logic signed [COORD_W-1:0] rect_height;
		logic [7:0]                draw_symbol;
		logic [7:0]                read_col;
		logic [7:0]                read_row;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic covered;
		logic near_edge;
	} pixel_hit_t;

endpackage

// ----- sv/rrc_pixel_test.sv -----
// Coverage test for one pixel against the held rectangle edges.
// Depends on rrc_pkg for coordinate widths and the hit struct.
// Used once per scan cycle by the sequencer in the top level.
module rrc_pixel_test import rrc_pkg::*; #(
	parameter int DIM_W     = 8,
	parameter int FRAC_BITS = 8
) (
	input  logic [DIM_W-1:0]        col,
	input  logic [DIM_W-1:0]        row,
	input  logic signed [SUM_W-1:0] x0,
	input  logic signed [SUM_W-1:0] x1,
	input  logic signed [SUM_W-1:0] y0,
	input  logic signed [SUM_W-1:0] y1,
	output pixel_hit_t              hit
);

	localparam int PIX_W = DIM_W + FRAC_BITS + 1;
	localparam int CMP_W = ((PIX_W > SUM_W + 1) ? PIX_W : SUM_W + 1) + 2;
	localparam logic signed [CMP_W-1:0] ONE = CMP_W'(1) << FRAC_BITS;

	logic signed [CMP_W-1:0] px;
	logic signed [CMP_W-1:0] py;
	logic signed [CMP_W-1:0] dx0;
	logic signed [CMP_W-1:0] dx1;
	logic signed [CMP_W-1:0] dy0;
	logic signed [CMP_W-1:0] dy1;

	assign px  = signed'(CMP_W'(col) << FRAC_BITS);
	assign py  = signed'(CMP_W'(row) << FRAC_BITS);
	assign dx0 = px - CMP_W'(x0);
	assign dx1 = CMP_W'(x1) - px;
	assign dy0 = py - CMP_W'(y0);
	assign dy1 = CMP_W'(y1) - py;

	// All four distances are non-negative once the pixel is covered.
	assign hit.covered   = !dx0[CMP_W-1] && !dx1[CMP_W-1] &&
	                       !dy0[CMP_W-1] && !dy1[CMP_W-1];
	assign hit.near_edge = (dx0 < ONE) || (dx1 < ONE) || (dy0 < ONE) || (dy1 < ONE);

endmodule

// ----- sv/rrc_canvas_mem.sv -----
// Pixel store of the canvas: one write port, one registered read port.
// Addressed by row and column concatenated.
// No dependencies.
module rrc_canvas_mem #(
	parameter int DIM_W = 8
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [2*DIM_W-1:0] wr_addr,
	input  logic [7:0]         wr_data,
	input  logic [2*DIM_W-1:0] rd_addr,
	output logic [7:0]         rd_data
);

	localparam int DEPTH = 1 << (2 * DIM_W);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- sv/rectangle_raster_canvas_core.sv -----
// Top level of the rectangle raster canvas: sequencer, registers, beats.
// Depends on rrc_pkg, rrc_pixel_test and rrc_canvas_mem.
// Configuration is written through a plain write port.

// A clear or draw beat scans the canvas one pixel per cycle through the single
// write port of the pixel store, over width * height pixels; a read passes a
// read state, a rejected draw or unused command goes to the done state. The input
// is not ready while a beat is being worked on; a finished result sits in the
// output register so the next beat can be taken before it leaves. The store is
// not initialized at reset: clear the canvas before reading it.
module rectangle_raster_canvas_core import rrc_pkg::*; #(
	parameter int MAX_DIM   = 256,
	parameter int FRAC_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_R = $clog2(MAX_DIM + 1);
	localparam int CNT_W = (CNT_R > CFG_W) ? CNT_R : CFG_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIM);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_READ = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] width_cfg_q;
	logic [CFG_W-1:0] height_cfg_q;
	logic [7:0]       bg_q;

	logic [CNT_W-1:0]        w_q;
	logic [CNT_W-1:0]        h_q;
	logic [DIM_W-1:0]        col_q;
	logic [DIM_W-1:0]        row_q;
	logic signed [SUM_W-1:0] x0_q;
	logic signed [SUM_W-1:0] x1_q;
	logic signed [SUM_W-1:0] y0_q;
	logic signed [SUM_W-1:0] y1_q;
	logic                    fill_q;
	logic                    clear_q;
	logic                    read_q;
	logic [7:0]              val_q;
	logic [1:0]              status_q;

	logic [CNT_W-1:0] w_eff;
	logic [CNT_W-1:0] h_eff;
	logic [CNT_W-1:0] w_ext;
	logic [CNT_W-1:0] h_ext;
	logic             accept;
	logic             last_col;
	logic             last_row;
	logic             out_free;
	logic             wr_en;
	logic [15:0]      rcol_ext;
	logic [15:0]      rrow_ext;
	logic [7:0]       rd_data;
	pixel_hit_t       hit;

	assign w_ext = CNT_W'(width_cfg_q);
	assign h_ext = CNT_W'(height_cfg_q);
	assign w_eff = (w_ext == '0) ? CNT_W'(1) : ((w_ext > MAX_CNT) ? MAX_CNT : w_ext);
	assign h_eff = (h_ext == '0) ? CNT_W'(1) : ((h_ext > MAX_CNT) ? MAX_CNT : h_ext);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign last_col = (CNT_W'(col_q) == w_q - CNT_W'(1));
	assign last_row = (CNT_W'(row_q) == h_q - CNT_W'(1));
	assign rcol_ext = 16'(in_data.read_col);
	assign rrow_ext = 16'(in_data.read_row);

	assign wr_en = (state_q == ST_SCAN) && (clear_q || (hit.covered && (fill_q || hit.near_edge)));

	rrc_pixel_test #(
		.DIM_W     (DIM_W),
		.FRAC_BITS (FRAC_BITS)
	) u_test (
		.col (col_q),
		.row (row_q),
		.x0  (x0_q),
		.x1  (x1_q),
		.y0  (y0_q),
		.y1  (y1_q),
		.hit (hit)
	);

	rrc_canvas_mem #(
		.DIM_W (DIM_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr ({row_q, col_q}),
		.wr_data (val_q),
		.rd_addr ({row_q, col_q}),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q  <= CFG_W'(1);
			height_cfg_q <= CFG_W'(1);
			bg_q         <= 8'd32;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CANVAS_WIDTH:  width_cfg_q  <= cfg_wdata;
				REG_CANVAS_HEIGHT: height_cfg_q <= cfg_wdata;
				REG_BACKGROUND:    bg_q         <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd_t'(in_data.command))
							CMD_CLEAR: state_q <= ST_SCAN;
							CMD_DRAW: begin
								if (in_data.rect_width <= 0 || in_data.rect_height <= 0) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							CMD_READ: state_q <= ST_READ;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					if (last_col && last_row) begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_q      <= w_eff;
			h_q      <= h_eff;
			x0_q     <= SUM_W'(in_data.rect_x);
			x1_q     <= SUM_W'(in_data.rect_x) + SUM_W'(in_data.rect_width);
			y0_q     <= SUM_W'(in_data.rect_y);
			y1_q     <= SUM_W'(in_data.rect_y) + SUM_W'(in_data.rect_height);
			fill_q   <= in_data.fill_mode;
			clear_q  <= (in_data.command == CMD_CLEAR);
			read_q   <= 1'b0;
			val_q    <= (in_data.command == CMD_CLEAR) ? bg_q : in_data.draw_symbol;
			status_q <= STATUS_OK;
			col_q    <= '0;
			row_q    <= '0;
			unique case (cmd_t'(in_data.command))
				CMD_DRAW: begin
					if (in_data.rect_width <= 0 || in_data.rect_height <= 0) begin
						status_q <= STATUS_BAD_SIZE;
					end
				end
				CMD_READ: begin
					if (CNT_W'(in_data.read_col) >= w_eff ||
					    CNT_W'(in_data.read_row) >= h_eff) begin
						status_q <= STATUS_OUTSIDE;
					end else begin
						read_q <= 1'b1;
						col_q  <= rcol_ext[DIM_W-1:0];
						row_q  <= rrow_ext[DIM_W-1:0];
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_SCAN) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= row_q + DIM_W'(1);
			end else begin
				col_q <= col_q + DIM_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data.pixel_value <= read_q ? rd_data : 8'd0;
			out_data.status      <= status_q;
		end
	end

endmodule

// ----- verif/rectangle_raster_canvas_core_tb.sv -----
// Self-checking testbench for rectangle_raster_canvas_core: a directed table, then random beats.
// A canvas copy predicts results not fixed in the table. Depends on rrc_pkg and the core RTL.
`timescale 1ns / 100ps
module rectangle_raster_canvas_core_tb;
	import rrc_pkg::*;

	localparam int MAX_DIM   = 256;
	localparam int FRAC_BITS = 8;
	localparam logic [7:0] SYM_UPPER_R = "R";
	localparam logic [7:0] SYM_LOWER_R = "r";

	typedef struct {
		bit               is_reg;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] val;
		in_item_t         beat;
		bit               fixed;
		out_item_t        want;
	} plan_row_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_item_t         in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_data;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	logic [7:0]       canvas_px [0:MAX_DIM*MAX_DIM-1];
	logic [CFG_W-1:0] cfg_cols       = 9'd1;
	logic [CFG_W-1:0] cfg_rows       = 9'd1;
	logic [7:0]       cfg_background = 8'd32;

	out_item_t pending_results [$];
	plan_row_t plan [$];
	int send_gap_pct  = 12;
	int recv_gap_pct  = 53;
	int fail_count    = 0;
	int beats_sent    = 0;
	int results_seen  = 0;
	int settings_used = 0;

	rectangle_raster_canvas_core #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_size(input logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	function automatic longint span(input longint a, input longint b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic out_item_t apply_command(input in_item_t beat);
		out_item_t res;
		int cols, rows;
		longint unit, lx, ty, wd, ht, rx2, by2, px, py;
		res = '0;
		res.status = STATUS_OK;
		cols = eff_size(cfg_cols);
		rows = eff_size(cfg_rows);
		unit = longint'(1) << FRAC_BITS;
		case (cmd_t'(beat.command))
			CMD_CLEAR: begin
				for (int r = 0; r < rows; r++)
					for (int c = 0; c < cols; c++)
						canvas_px[r*MAX_DIM + c] = cfg_background;
			end
			CMD_DRAW: begin
				lx = longint'($signed(beat.rect_x));
				ty = longint'($signed(beat.rect_y));
				wd = longint'($signed(beat.rect_width));
				ht = longint'($signed(beat.rect_height));
				if (wd <= 0 || ht <= 0) begin
					res.status = STATUS_BAD_SIZE;
				end else begin
					rx2 = lx + wd;
					by2 = ty + ht;
					for (int r = 0; r < rows; r++) begin
						py = longint'(r) * unit;
						if (py >= ty && py <= by2) begin
							for (int c = 0; c < cols; c++) begin
								px = longint'(c) * unit;
								if (px >= lx && px <= rx2 && (beat.fill_mode == 1'b1 ||
										span(px, lx) < unit || span(px, rx2) < unit ||
										span(py, ty) < unit || span(py, by2) < unit))
									canvas_px[r*MAX_DIM + c] = beat.draw_symbol;
							end
						end
					end
				end
			end
			CMD_READ: begin
				if (int'(beat.read_col) >= cols || int'(beat.read_row) >= rows)
					res.status = STATUS_OUTSIDE;
				else
					res.pixel_value = canvas_px[int'(beat.read_row)*MAX_DIM + int'(beat.read_col)];
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic in_item_t mk_cmd(input cmd_t code);
		in_item_t b;
		b = '0;
		b.command = code;
		return b;
	endfunction

	function automatic in_item_t mk_read(input int col, input int row);
		in_item_t b;
		b = mk_cmd(CMD_READ);
		b.read_col = 8'(col);
		b.read_row = 8'(row);
		return b;
	endfunction

	function automatic in_item_t mk_draw(input bit filled, input int x, input int y,
			input int w, input int h, input logic [7:0] sym);
		in_item_t b;
		b = mk_cmd(CMD_DRAW);
		b.fill_mode   = filled;
		b.rect_x      = 24'(x);
		b.rect_y      = 24'(y);
		b.rect_width  = 24'(w);
		b.rect_height = 24'(h);
		b.draw_symbol = sym;
		return b;
	endfunction

	function automatic void add_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		plan_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.idx    = idx;
		row.val    = val;
		plan.push_back(row);
	endfunction

	function automatic void add_beat(input in_item_t beat, input bit fixed,
			input logic [7:0] px, input status_t st);
		plan_row_t row;
		row = '{default: '0};
		row.beat              = beat;
		row.fixed             = fixed;
		row.want.pixel_value  = px;
		row.want.status       = st;
		plan.push_back(row);
	endfunction

	function automatic in_item_t random_beat();
		in_item_t b;
		int cols, rows, pick;
		cols = eff_size(cfg_cols);
		rows = eff_size(cfg_rows);
		b.fill_mode   = 1'($urandom());
		b.rect_x      = 24'($urandom());
		b.rect_y      = 24'($urandom());
		b.rect_width  = 24'($urandom());
		b.rect_height = 24'($urandom());
		b.draw_symbol = 8'($urandom());
		b.read_col    = 8'($urandom());
		b.read_row    = 8'($urandom());
		pick = $urandom_range(99);
		if (pick < 6) begin
			b.command = CMD_CLEAR;
		end else if (pick < 10) begin
			b.command = CMD_NONE;
		end else if (pick < 55) begin
			b.command = CMD_DRAW;
			pick = $urandom_range(99);
			if (pick < 80) begin
				b.rect_x      = 24'($urandom_range(0, (cols + 4) * 256) - 512);
				b.rect_y      = 24'($urandom_range(0, (rows + 4) * 256) - 512);
				b.rect_width  = 24'($urandom_range(1, (cols + 2) * 256));
				b.rect_height = 24'($urandom_range(1, (rows + 2) * 256));
			end else if (pick < 86) begin
				if (pick[0])
					b.rect_width = '0;
				else
					b.rect_height = '0;
			end
		end else begin
			b.command = CMD_READ;
			if ($urandom_range(99) < 80) begin
				b.read_col = 8'($urandom_range(0, cols - 1));
				b.read_row = 8'($urandom_range(0, rows - 1));
			end
		end
		return b;
	endfunction

	task automatic send_beat(input in_item_t beat, input bit fixed, input out_item_t want);
		out_item_t guess;
		cfg_we <= 1'b0;
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_gap_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		guess = apply_command(beat);
		pending_results.push_back(fixed ? want : guess);
		beats_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_register(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_CANVAS_WIDTH:  cfg_cols = val;
			REG_CANVAS_HEIGHT: cfg_rows = val;
			REG_BACKGROUND:    cfg_background = val[7:0];
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: pixel_value %0h status %0d",
					out_data.pixel_value, out_data.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (out_data.pixel_value !== want.pixel_value) begin
					$error("pixel_value mismatch: expected %0h, got %0h",
						want.pixel_value, out_data.pixel_value);
					fail_count++;
				end
				if (out_data.status !== want.status) begin
					$error("status mismatch: expected %0d, got %0d", want.status, out_data.status);
					fail_count++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_gap_pct);
	end

	initial begin
		#100_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		out_item_t none;
		bit wide;
		none = '0;
		for (int i = 0; i < MAX_DIM*MAX_DIM; i++)
			canvas_px[i] = 8'd0;

		add_beat(mk_cmd(CMD_CLEAR), 1, 8'd0, STATUS_OK);
		add_beat(mk_read(0, 0), 1, 8'd32, STATUS_OK);
		add_beat(mk_read(1, 0), 1, 8'd0, STATUS_OUTSIDE);
		add_beat(mk_read(0, 1), 1, 8'd0, STATUS_OUTSIDE);
		add_beat(in_item_t'({CMD_NONE, {121{1'b1}}}), 1, 8'd0, STATUS_OK);
		add_beat(mk_draw(1, 0, 0, 0, 256, SYM_UPPER_R), 1, 8'd0, STATUS_BAD_SIZE);
		add_beat(mk_draw(0, 0, 0, 256, 'h800000, SYM_UPPER_R), 1, 8'd0, STATUS_BAD_SIZE);
		add_beat(mk_draw(1, 0, 0, -1, 256, SYM_UPPER_R), 1, 8'd0, STATUS_BAD_SIZE);
		add_beat(mk_draw(1, 0, 0, 1, 1, SYM_UPPER_R), 1, 8'd0, STATUS_OK);
		add_beat(mk_read(0, 0), 1, SYM_UPPER_R, STATUS_OK);
		add_reg(REG_CANVAS_WIDTH, 9'd511);
		add_reg(REG_CANVAS_HEIGHT, 9'd0);
		add_reg(REG_BACKGROUND, 9'hFF);
		add_beat(mk_cmd(CMD_CLEAR), 1, 8'd0, STATUS_OK);
		add_beat(mk_read(255, 0), 1, 8'hFF, STATUS_OK);
		add_beat(mk_read(0, 1), 1, 8'd0, STATUS_OUTSIDE);
		add_beat(mk_draw(0, 'h800000, 'h800000, 'h7FFFFF, 'h7FFFFF, SYM_LOWER_R), 0, 8'd0,
			STATUS_OK);
		add_beat(mk_draw(1, 'h7FFFFF, 0, 'h7FFFFF, 'h7FFFFF, SYM_LOWER_R), 0, 8'd0, STATUS_OK);
		add_beat(mk_draw(0, 'h280, -'h80, 'h500, 'h100, SYM_LOWER_R), 0, 8'd0, STATUS_OK);
		add_beat(mk_read(5, 0), 0, 8'd0, STATUS_OK);
		add_reg(REG_CANVAS_WIDTH, 9'd16);
		add_reg(REG_CANVAS_HEIGHT, 9'd300);
		add_reg(REG_BACKGROUND, 9'd0);
		add_beat(mk_cmd(CMD_CLEAR), 0, 8'd0, STATUS_OK);
		add_beat(mk_draw(0, 'h200, 'h300, 'h800, 'h600, SYM_UPPER_R), 0, 8'd0, STATUS_OK);
		add_beat(mk_read(5, 6), 0, 8'd0, STATUS_OK);
		add_beat(mk_read(2, 5), 0, 8'd0, STATUS_OK);
		add_beat(mk_draw(1, 'h180, 'h40, 'h300, 'h200, 8'hFF), 0, 8'd0, STATUS_OK);
		add_beat(mk_read(3, 1), 0, 8'd0, STATUS_OK);
		add_reg(REG_CANVAS_WIDTH, 9'd4);
		add_reg(REG_CANVAS_HEIGHT, 9'd4);
		add_beat(mk_read(3, 2), 0, 8'd0, STATUS_OK);
		add_beat(mk_read(4, 0), 1, 8'd0, STATUS_OUTSIDE);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				wait_idle();
				set_register(reg_idx_t'(plan[i].idx), plan[i].val);
			end else begin
				send_beat(plan[i].beat, plan[i].fixed, plan[i].want);
			end
		end
		settings_used = 4;

		for (int phase = 0; phase < 7; phase++) begin
			send_gap_pct = (phase < 2) ? 12 : (phase < 4) ? 53 : 0;
			recv_gap_pct = (phase < 2) ? 53 : (phase < 4) ? 12 : 0;
			wait_idle();
			if (phase == 6) begin
				set_register(REG_CANVAS_WIDTH, 9'd256);
				set_register(REG_CANVAS_HEIGHT, 9'd256);
			end else begin
				wide = ($urandom_range(7) == 0);
				set_register(REG_CANVAS_WIDTH,
					wide ? 9'($urandom_range(257, 511)) : 9'($urandom_range(0, 20)));
				set_register(REG_CANVAS_HEIGHT, (!wide && $urandom_range(7) == 0) ?
					9'($urandom_range(256, 511)) : 9'($urandom_range(0, 20)));
			end
			set_register(REG_BACKGROUND, 9'($urandom_range(0, 255)));
			settings_used++;
			send_beat(mk_cmd(CMD_CLEAR), 0, none);
			if (phase == 6) begin
				send_beat(mk_draw(0, 0, 0, 255 * 256, 255 * 256, SYM_UPPER_R), 0, none);
				repeat (6) send_beat(random_beat(), 0, none);
			end else begin
				repeat (10) send_beat(random_beat(), 0, none);
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Sent %0d beats (%0d directed) over %0d canvas settings; checked %0d results.",
			beats_sent, plan.size() - 8, settings_used, results_seen);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
